FILE: sv/xerr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xerr_pkg
// shared types and character constants for the reference recognizer
// ----------------------------------------------------------------------------
package xerr_pkg;

    localparam int CP_W = 21;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_SEMI = 8'h3b;

    typedef enum logic [3:0] {
        PH_DONE       = 4'd0,
        PH_LEAD       = 4'd1,
        PH_HASH       = 4'd2,
        PH_DEC_MORE   = 4'd3,
        PH_HEX_FIRST  = 4'd4,
        PH_HEX_MORE   = 4'd5,
        PH_NAME_NEXT  = 4'd6,
        PH_CONT_START = 4'd7,
        PH_CONT_NEXT  = 4'd8
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic              lead_amp;
        logic [CP_W-1:0]   acc;
        logic [1:0]        bytes_left;
        logic [1:0]        seq_len;
    } xerr_state_t;

    typedef struct packed {
        logic verdict_valid;
        logic is_entity;
    } xerr_verdict_t;

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) ||
                 ((b >= 8'h41) && (b <= 8'h46));
    endfunction

endpackage

FILE: sv/xerr_cpclass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xerr_cpclass
// classifies a code point as name start char and as name char
// ----------------------------------------------------------------------------
module xerr_cpclass (
    input  logic [xerr_pkg::CP_W-1:0] cp,
    output logic                      start_ok,
    output logic                      name_ok,
    output logic [1:0]                nat_len
);
    import xerr_pkg::*;

    always_comb
    begin
        start_ok = (cp == 21'h3a) || (cp == 21'h5f) ||
                   (cp >= 21'h41 && cp <= 21'h5a) ||
                   (cp >= 21'h61 && cp <= 21'h7a) ||
                   (cp >= 21'hc0 && cp <= 21'hd6) ||
                   (cp >= 21'hd8 && cp <= 21'hf6) ||
                   (cp >= 21'hf8 && cp <= 21'h2ff) ||
                   (cp >= 21'h370 && cp <= 21'h37d) ||
                   (cp >= 21'h37f && cp <= 21'h1fff) ||
                   (cp >= 21'h200c && cp <= 21'h200d) ||
                   (cp >= 21'h2070 && cp <= 21'h218f) ||
                   (cp >= 21'h2c00 && cp <= 21'h2fef) ||
                   (cp >= 21'h3001 && cp <= 21'hd7ff) ||
                   (cp >= 21'hf900 && cp <= 21'hfdcf) ||
                   (cp >= 21'hfdf0 && cp <= 21'hfffd) ||
                   (cp >= 21'h10000 && cp <= 21'heffff);

        name_ok = start_ok || (cp == 21'h2d) || (cp == 21'h2e) ||
                  (cp >= 21'h30 && cp <= 21'h39) || (cp == 21'hb7) ||
                  (cp >= 21'h300 && cp <= 21'h36f) ||
                  (cp >= 21'h203f && cp <= 21'h2040);

        // encoded length minus one
        if (cp <= 21'h7f)
            nat_len = 2'd0;
        else if (cp <= 21'h7ff)
            nat_len = 2'd1;
        else if (cp <= 21'hffff)
            nat_len = 2'd2;
        else
            nat_len = 2'd3;
    end

endmodule

FILE: sv/xerr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xerr_step
// next-state and verdict logic for one byte of the string
// ----------------------------------------------------------------------------
module xerr_step (
    input  xerr_pkg::xerr_state_t   state,
    input  logic [7:0]              data_byte,
    input  logic                    first,
    output xerr_pkg::xerr_state_t   state_next,
    output xerr_pkg::xerr_verdict_t verdict
);
    import xerr_pkg::*;

    logic [CP_W-1:0] acc_shift;
    logic [1:0]      left_dec;
    logic            in_cont;
    logic [CP_W-1:0] cls_cp;
    logic            cls_start;
    logic            cls_name;
    logic [1:0]      cls_len;
    logic            want_start;
    logic            char_ok;
    logic            decided;
    logic            accept;

    assign acc_shift = {state.acc[CP_W-7:0], data_byte[5:0]};
    assign left_dec  = state.bytes_left - 2'd1;
    assign in_cont   = (state.phase == PH_CONT_START) || (state.phase == PH_CONT_NEXT);
    assign cls_cp    = in_cont ? acc_shift : {{(CP_W-8){1'b0}}, data_byte};

    xerr_cpclass u_cpclass (
        .cp       (cls_cp),
        .start_ok (cls_start),
        .name_ok  (cls_name),
        .nat_len  (cls_len)
    );

    assign want_start = (state.phase == PH_LEAD) || (state.phase == PH_CONT_START);
    assign char_ok    = want_start ? cls_start : cls_name;

    always_comb
    begin
        state_next = state;
        decided    = 1'b0;
        accept     = 1'b0;

        if (first) begin
            state_next.lead_amp   = (data_byte == CH_AMP);
            state_next.bytes_left = 2'd0;
            if (data_byte == CH_NUL)
                decided = 1'b1;
            else
                state_next.phase = PH_LEAD;
        end else begin
            unique case (state.phase) inside
                PH_LEAD, PH_NAME_NEXT:
                begin
                    if (state.phase == PH_LEAD && state.lead_amp && data_byte == CH_HASH)
                        state_next.phase = PH_HASH;
                    else if (state.phase == PH_NAME_NEXT && data_byte == CH_SEMI) begin
                        decided = 1'b1;
                        accept  = 1'b1;
                    end else if (!data_byte[7]) begin
                        if (char_ok)
                            state_next.phase = PH_NAME_NEXT;
                        else
                            decided = 1'b1;
                    end else if (data_byte[7:5] == 3'b110) begin
                        state_next.acc        = {{(CP_W-5){1'b0}}, data_byte[4:0]};
                        state_next.bytes_left = 2'd1;
                        state_next.seq_len    = 2'd1;
                    end else if (data_byte[7:4] == 4'b1110) begin
                        state_next.acc        = {{(CP_W-4){1'b0}}, data_byte[3:0]};
                        state_next.bytes_left = 2'd2;
                        state_next.seq_len    = 2'd2;
                    end else if (data_byte[7:3] == 5'b11110) begin
                        state_next.acc        = {{(CP_W-3){1'b0}}, data_byte[2:0]};
                        state_next.bytes_left = 2'd3;
                        state_next.seq_len    = 2'd3;
                    end else
                        decided = 1'b1;
                    // multi-byte lead opens a continuation phase
                    if (data_byte[7] && !decided)
                        state_next.phase = (state.phase == PH_LEAD) ? PH_CONT_START
                                                                    : PH_CONT_NEXT;
                end
                PH_HASH:
                begin
                    if (data_byte == CH_X)
                        state_next.phase = PH_HEX_FIRST;
                    else if (is_digit(data_byte))
                        state_next.phase = PH_DEC_MORE;
                    else
                        decided = 1'b1;
                end
                PH_DEC_MORE:
                begin
                    if (data_byte == CH_SEMI) begin
                        decided = 1'b1;
                        accept  = 1'b1;
                    end else if (!is_digit(data_byte))
                        decided = 1'b1;
                end
                PH_HEX_FIRST:
                begin
                    if (is_hex(data_byte))
                        state_next.phase = PH_HEX_MORE;
                    else
                        decided = 1'b1;
                end
                PH_HEX_MORE:
                begin
                    if (data_byte == CH_SEMI) begin
                        decided = 1'b1;
                        accept  = 1'b1;
                    end else if (!is_hex(data_byte))
                        decided = 1'b1;
                end
                PH_CONT_START, PH_CONT_NEXT:
                begin
                    if (data_byte[7:6] != 2'b10)
                        decided = 1'b1;
                    else begin
                        state_next.acc        = acc_shift;
                        state_next.bytes_left = left_dec;
                        if (left_dec == 2'd0) begin
                            // overlong forms fail the length check
                            if (cls_len == state.seq_len && char_ok)
                                state_next.phase = PH_NAME_NEXT;
                            else
                                decided = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (decided) begin
            state_next.phase      = PH_DONE;
            state_next.bytes_left = 2'd0;
        end

        verdict.verdict_valid = decided;
        verdict.is_entity     = decided && accept;
    end

endmodule

FILE: sv/xml_entity_reference_recognizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_reference_recognizer_core
// byte-stream recognizer for xml character and entity references
// ----------------------------------------------------------------------------
// Takes one byte of a string per request (first marks a new string, a zero
// byte ends it) and emits one result per byte: verdict_valid is high on the
// byte that decides whether the string begins with "&#x" hex digits ';',
// "&#" decimal digits ';', or a byte followed by an xml name and ';', and
// is_entity then gives the answer. Name characters are decoded from utf-8
// and checked against the name start / name char ranges. Throughput is one
// byte per clock: a request is registered on accept, then the per-byte state
// update and character range compares run on the registered byte and load
// the result register when it is free. Both stages hold under backpressure,
// and the input side keeps accepting while a result waits as long as the
// result register is freed that cycle.
// ----------------------------------------------------------------------------
module xml_entity_reference_recognizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       first,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       verdict_valid,
    output logic       is_entity
);
    import xerr_pkg::*;

    // input stage
    logic          in_vld_reg;
    logic [7:0]    byte_reg;
    logic          first_reg;

    // recognizer state
    xerr_state_t   state_reg;
    xerr_state_t   state_next;
    xerr_verdict_t verdict_next;

    // result stage
    logic          out_vld_reg;
    xerr_verdict_t verdict_reg;

    logic          advance;
    logic          in_take;

    // the input request moves on when the result register is free
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign in_take  = in_valid && in_ready;

    xerr_step u_step (
        .state      (state_reg),
        .data_byte  (byte_reg),
        .first      (first_reg),
        .state_next (state_next),
        .verdict    (verdict_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '{phase: PH_DONE, lead_amp: 1'b0, acc: '0,
                             bytes_left: 2'd0, seq_len: 2'd0};
        end else begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance) begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            byte_reg  <= data_byte;
            first_reg <= first;
        end
        if (advance)
            verdict_reg <= verdict_next;
    end

    assign out_valid     = out_vld_reg;
    assign verdict_valid = verdict_reg.verdict_valid;
    assign is_entity     = verdict_reg.is_entity;

`ifndef SYNTHESIS
    // a positive answer is only ever given together with a verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!is_entity || verdict_valid))
    else $error("is_entity without verdict_valid");

    // a request leaving the input stage always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
    else $error("advanced request lost");

    // after a verdict the recognizer waits for a new string
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && verdict_next.verdict_valid) |=> (state_reg.phase == PH_DONE))
    else $error("state not done after verdict");

    // continuation bytes are only pending inside a utf-8 sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.bytes_left != 2'd0) |->
            (state_reg.phase == PH_CONT_START || state_reg.phase == PH_CONT_NEXT))
    else $error("bytes_left outside continuation phase");
`endif

endmodule

FILE: tb/xml_entity_reference_recognizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_reference_recognizer_core_tb
// self-checking bench for the xml reference recognizer
// ----------------------------------------------------------------------------
// Feeds strings to the recognizer one byte per request. A short directed set
// covers each reference form and the main reject cases. A long random run
// follows. It builds mostly well-formed hex, decimal and name references with
// random utf-8 content, mutates some of them, and mixes in raw noise. A
// scoreboard tracks the recognizer state on every accepted byte, queues the
// verdict it predicts, and compares each returned result field by field.
// Both handshake sides idle and stall at random, with quiet stretches.
// ----------------------------------------------------------------------------
module xml_entity_reference_recognizer_core_tb;
    import xerr_pkg::*;

    localparam int ITEM_TARGET  = 2000;  // requests accepted by the block
    localparam int STUCK_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 8;     // idle cycles after the last result before finishing

    // ------------------------------------------------------------------------
    // scoreboard: tracks the recognizer state and holds pending verdicts
    // ------------------------------------------------------------------------
    class ref_scoreboard;
        phase_t          ph;
        logic            lead_amp;
        logic [CP_W-1:0] cp;
        logic [1:0]      left;
        logic [1:0]      seq_len;
        xerr_verdict_t   verdict_q[$];
        int              errors;
        int              results;
        int              accepted;
        int              rejected;

        function new();
            ph       = PH_DONE;
            lead_amp = 1'b0;
            cp       = '0;
            left     = 2'd0;
            seq_len  = 2'd0;
            errors   = 0;
            results  = 0;
            accepted = 0;
            rejected = 0;
        endfunction

        function bit dec_digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit hex_digit(logic [7:0] b);
            return dec_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
        endfunction

        function bit start_cp(logic [CP_W-1:0] c);
            return c == ":" || c == "_" || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z") || (c >= 'hc0 && c <= 'hd6) ||
                   (c >= 'hd8 && c <= 'hf6) || (c >= 'hf8 && c <= 'h2ff) ||
                   (c >= 'h370 && c <= 'h37d) || (c >= 'h37f && c <= 'h1fff) ||
                   (c >= 'h200c && c <= 'h200d) || (c >= 'h2070 && c <= 'h218f) ||
                   (c >= 'h2c00 && c <= 'h2fef) || (c >= 'h3001 && c <= 'hd7ff) ||
                   (c >= 'hf900 && c <= 'hfdcf) || (c >= 'hfdf0 && c <= 'hfffd) ||
                   (c >= 'h10000 && c <= 'heffff);
        endfunction

        function bit name_cp(logic [CP_W-1:0] c);
            return start_cp(c) || c == "-" || c == "." || (c >= "0" && c <= "9") ||
                   c == 'hb7 || (c >= 'h300 && c <= 'h36f) ||
                   (c >= 'h203f && c <= 'h2040);
        endfunction

        // shortest utf-8 length minus one
        function logic [1:0] enc_len(logic [CP_W-1:0] c);
            if (c <= 'h7f) return 2'd0;
            if (c <= 'h7ff) return 2'd1;
            if (c <= 'hffff) return 2'd2;
            return 2'd3;
        endfunction

        // 0 reject, 1 single-byte char taken, 2 multi-byte sequence opened
        function int lead_char(logic [7:0] b, bit at_start);
            if (b < 8'h80)
                return (at_start ? start_cp(CP_W'(b)) : name_cp(CP_W'(b))) ? 1 : 0;
            if (b >= 8'hc0 && b <= 8'hdf) begin
                cp = {{(CP_W-5){1'b0}}, b[4:0]}; left = 2'd1; seq_len = 2'd1;
                return 2;
            end
            if (b >= 8'he0 && b <= 8'hef) begin
                cp = {{(CP_W-4){1'b0}}, b[3:0]}; left = 2'd2; seq_len = 2'd2;
                return 2;
            end
            if (b >= 8'hf0 && b <= 8'hf7) begin
                cp = {{(CP_W-3){1'b0}}, b[2:0]}; left = 2'd3; seq_len = 2'd3;
                return 2;
            end
            return 0;
        endfunction

        // advance on an accepted request; returns 1 unless the byte is ignored
        function bit note_request(logic [7:0] b, logic f);
            int decided;
            int r;
            bit live;
            bit ok;
            decided = -1;
            live = f || (ph != PH_DONE);
            if (f) begin
                lead_amp = (b == CH_AMP);
                left = 2'd0;
                if (b == CH_NUL) decided = 0;
                else ph = PH_LEAD;
            end else begin
                case (ph) inside
                    PH_LEAD: begin
                        if (lead_amp && b == CH_HASH) ph = PH_HASH;
                        else begin
                            r = lead_char(b, 1'b1);
                            if (r == 0) decided = 0;
                            else ph = (r == 1) ? PH_NAME_NEXT : PH_CONT_START;
                        end
                    end
                    PH_HASH: begin
                        if (b == CH_X) ph = PH_HEX_FIRST;
                        else if (dec_digit(b)) ph = PH_DEC_MORE;
                        else decided = 0;
                    end
                    PH_DEC_MORE: begin
                        if (b == CH_SEMI) decided = 1;
                        else if (!dec_digit(b)) decided = 0;
                    end
                    PH_HEX_FIRST: begin
                        if (hex_digit(b)) ph = PH_HEX_MORE;
                        else decided = 0;
                    end
                    PH_HEX_MORE: begin
                        if (b == CH_SEMI) decided = 1;
                        else if (!hex_digit(b)) decided = 0;
                    end
                    PH_NAME_NEXT: begin
                        if (b == CH_SEMI) decided = 1;
                        else begin
                            r = lead_char(b, 1'b0);
                            if (r == 0) decided = 0;
                            else if (r == 2) ph = PH_CONT_NEXT;
                        end
                    end
                    PH_CONT_START, PH_CONT_NEXT: begin
                        if (b[7:6] != 2'b10) decided = 0;
                        else begin
                            cp = {cp[CP_W-7:0], b[5:0]};
                            left = left - 2'd1;
                            if (left == 2'd0) begin
                                ok = (enc_len(cp) == seq_len) &&
                                     (ph == PH_CONT_START ? start_cp(cp) : name_cp(cp));
                                if (ok) ph = PH_NAME_NEXT;
                                else decided = 0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            verdict_q.push_back('{verdict_valid: decided >= 0, is_entity: decided == 1});
            if (decided >= 0) begin
                ph = PH_DONE;
                left = 2'd0;
            end
            return live;
        endfunction

        function void check_result(logic vv, logic ie);
            xerr_verdict_t want;
            if (verdict_q.size() == 0) begin
                $display("%0t: result with no request pending (verdict_valid %0b is_entity %0b)",
                         $time, vv, ie);
                errors++;
                return;
            end
            want = verdict_q.pop_front();
            results++;
            if (vv !== want.verdict_valid) begin
                $display("%0t: verdict_valid mismatch, expected %0b, actual %0b",
                         $time, want.verdict_valid, vv);
                errors++;
            end
            if (ie !== want.is_entity) begin
                $display("%0t: is_entity mismatch, expected %0b, actual %0b",
                         $time, want.is_entity, ie);
                errors++;
            end
            if (want.verdict_valid)
                if (want.is_entity) accepted++;
                else rejected++;
        endfunction

        function int outstanding();
            return verdict_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and the block
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       first     = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic       verdict_valid;
    logic       is_entity;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    xml_entity_reference_recognizer_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .first         (first),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .verdict_valid (verdict_valid),
        .is_entity     (is_entity)
    );

    ref_scoreboard sb;
    int            req_items;     // every accepted request
    int            live_items;    // requests that were not ignored
    int            strings_sent;
    int            stuck_cycles;
    bit            calm;          // sender quiet stretch, no gaps
    logic [7:0]    str_q[$];      // bytes of the string being sent

    // ------------------------------------------------------------------------
    // monitor and watchdog: sampled at the edge, before this edge's updates
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                req_items++;
                if (sb.note_request(data_byte, first))
                    live_items++;
            end
            if (out_valid && out_ready)
                sb.check_result(verdict_valid, is_entity);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results still pending",
                         $time, STUCK_LIMIT, sb.outstanding());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side: ready runs high or low for random stretches
    // ------------------------------------------------------------------------
    int  rdy_run = 0;
    bit  rdy_level = 1'b1;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rdy_run == 0)
            begin
                rdy_level = !rdy_level;
                if (rdy_level)
                    // occasionally a long stretch with no stalls at all
                    rdy_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 30);
                else
                    rdy_run = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25)
                                                          : $urandom_range(1, 3);
            end
            out_ready <= rdy_level;
            rdy_run--;
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // valid goes low only across a gap, so it never drops and rises in one step
    task automatic send_byte(logic [7:0] b, logic f);
        int gap;
        gap = calm ? 0 : idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        first     <= f;
        do @(posedge clk); while (!in_ready);
    endtask

    // scatter adds a rare stray new-string mark inside the string
    task automatic send_string(bit scatter);
        for (int i = 0; i < str_q.size(); i++)
            send_byte(str_q[i], i == 0 || (scatter && $urandom_range(0, 49) == 0));
        strings_sent++;
    endtask

    // utf-8 encode, extra > 0 gives an overlong form
    function automatic void push_cp(logic [20:0] c, int extra);
        int n;
        n = sb.enc_len(c) + 1 + extra;
        if (n > 4) n = 4;
        case (n)
            1: str_q.push_back({1'b0, c[6:0]});
            2:
            begin
                str_q.push_back({3'b110, c[10:6]});
                str_q.push_back({2'b10, c[5:0]});
            end
            3:
            begin
                str_q.push_back({4'b1110, c[15:12]});
                str_q.push_back({2'b10, c[11:6]});
                str_q.push_back({2'b10, c[5:0]});
            end
            default:
            begin
                str_q.push_back({5'b11110, c[20:18]});
                str_q.push_back({2'b10, c[17:12]});
                str_q.push_back({2'b10, c[11:6]});
                str_q.push_back({2'b10, c[5:0]});
            end
        endcase
    endfunction

    // code point from one of the name ranges, leaning on the range edges
    // and sometimes stepping just outside
    function automatic logic [20:0] pick_cp(bit name_pos);
        int lo;
        int hi;
        case ($urandom_range(0, name_pos ? 21 : 15))
            0:  begin lo = ":";      hi = ":";      end
            1:  begin lo = "_";      hi = "_";      end
            2:  begin lo = "A";      hi = "Z";      end
            3:  begin lo = "a";      hi = "z";      end
            4:  begin lo = 'hc0;     hi = 'hd6;     end
            5:  begin lo = 'hd8;     hi = 'hf6;     end
            6:  begin lo = 'hf8;     hi = 'h2ff;    end
            7:  begin lo = 'h370;    hi = 'h37d;    end
            8:  begin lo = 'h37f;    hi = 'h1fff;   end
            9:  begin lo = 'h200c;   hi = 'h200d;   end
            10: begin lo = 'h2070;   hi = 'h218f;   end
            11: begin lo = 'h2c00;   hi = 'h2fef;   end
            12: begin lo = 'h3001;   hi = 'hd7ff;   end
            13: begin lo = 'hf900;   hi = 'hfdcf;   end
            14: begin lo = 'hfdf0;   hi = 'hfffd;   end
            15: begin lo = 'h10000;  hi = 'heffff;  end
            16: begin lo = "-";      hi = "-";      end
            17: begin lo = ".";      hi = ".";      end
            18: begin lo = "0";      hi = "9";      end
            19: begin lo = 'hb7;     hi = 'hb7;     end
            20: begin lo = 'h300;    hi = 'h36f;    end
            default: begin lo = 'h203f; hi = 'h2040; end
        endcase
        case ($urandom_range(0, 9))
            0:       return 21'(lo - 1);
            1:       return 21'(hi + 1);
            2:       return 21'(lo);
            3:       return 21'(hi);
            default: return 21'($urandom_range(hi, lo));
        endcase
    endfunction

    // one random string: hex, decimal or name reference, or plain noise,
    // with some references broken afterwards
    function automatic void build_random();
        string hexset;
        string missset;
        int    form;
        int    n;
        int    pos;
        int    nat;
        int    extra;
        logic [20:0] c;
        hexset  = "0123456789abcdefABCDEF";
        missset = "/:@G`g;#xX";
        str_q.delete();
        form = $urandom_range(0, 99);
        if (form < 22)
        begin
            str_q.push_back(CH_AMP);
            str_q.push_back(CH_HASH);
            str_q.push_back(CH_X);
            n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
            repeat (n) str_q.push_back(hexset[$urandom_range(0, 21)]);
            str_q.push_back(CH_SEMI);
        end
        else if (form < 40)
        begin
            str_q.push_back(CH_AMP);
            str_q.push_back(CH_HASH);
            n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
            repeat (n) str_q.push_back(hexset[$urandom_range(0, 9)]);
            str_q.push_back(CH_SEMI);
        end
        else if (form < 80)
        begin
            // lead byte is not looked at on the name path
            str_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : CH_AMP);
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++)
            begin
                c = pick_cp(k > 0);
                nat = sb.enc_len(c);
                extra = 0;
                if (nat < 3 && $urandom_range(0, 15) == 0)
                    extra = $urandom_range(1, 3 - nat);
                push_cp(c, extra);
            end
            str_q.push_back(CH_SEMI);
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n) str_q.push_back(8'($urandom_range(0, 255)));
        end

        if (form < 80 && $urandom_range(0, 99) < 35)
        begin
            pos = $urandom_range(1, str_q.size() - 1);
            case ($urandom_range(0, 4))
                0: str_q[$urandom_range(0, str_q.size() - 1)] = 8'($urandom_range(0, 255));
                1: while (str_q.size() > pos) void'(str_q.pop_back());
                2: str_q.insert(pos, CH_NUL);
                3: str_q[pos] = missset[$urandom_range(0, missset.len() - 1)];
                default: str_q.delete(pos);
            endcase
        end

        // bytes past the verdict, and sometimes a terminating zero
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) str_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0)
            str_q.push_back(CH_NUL);
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        req_items    = 0;
        live_items   = 0;
        strings_sent = 0;
        stuck_cycles = 0;
        calm         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // zero as the very first byte
        str_q = '{CH_NUL};
        send_string(1'b0);
        // hex reference, mixed case digits
        str_q = '{CH_AMP, CH_HASH, CH_X, "A", "f", CH_SEMI};
        send_string(1'b0);
        // empty decimal and empty hex numbers
        str_q = '{CH_AMP, CH_HASH, CH_SEMI};
        send_string(1'b0);
        str_q = '{CH_AMP, CH_HASH, CH_X, CH_SEMI};
        send_string(1'b0);
        // decimal reference
        str_q = '{CH_AMP, CH_HASH, "9", CH_SEMI};
        send_string(1'b0);
        // semicolon right away is no name start; the trailing byte is ignored
        str_q = '{CH_AMP, CH_SEMI, "q"};
        send_string(1'b0);
        // unchecked top lead byte, then a name with the middle dot inside
        str_q = '{8'hff, "A", 8'hc2, 8'hb7, CH_SEMI};
        send_string(1'b0);
        // stray continuation byte
        str_q = '{CH_AMP, 8'h80};
        send_string(1'b0);
        // overlong two-byte form of zero
        str_q = '{CH_AMP, 8'hc0, 8'h80};
        send_string(1'b0);

        while (req_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                calm = !calm;
            build_random();
            send_string(1'b1);
        end
        in_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d strings in %0d requests, %0d bytes reached the decoder",
                 strings_sent, req_items, live_items);
        $display("%0d results checked: %0d references recognized, %0d rejected, %0d errors",
                 sb.results, sb.accepted, sb.rejected, sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
